// ===== design/spom_pkg.sv =====
// ----------------------------------------------------------------------------
// spom_pkg
// Shared types and constants for the spiral-order matrix reader.
// ----------------------------------------------------------------------------
package spom_pkg;

  // Element payload width
  localparam int DATA_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] ROWS_RST = 4'd4;
  localparam logic [CFG_DATA_W-1:0] COLS_RST = 4'd4;

  // Control from the sequencer to the address walker
  typedef struct packed {
    logic start;  // load the first ring at the top-left corner
    logic step;   // move to the next element of the spiral
  } spom_walk_ctl_t;

endpackage

// ===== design/spom_store.sv =====
// ----------------------------------------------------------------------------
// spom_store
// Matrix element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spom_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [spom_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [spom_pkg::DATA_W-1:0] rd_data
);

  logic [spom_pkg::DATA_W-1:0] mem [DEPTH];
  logic [spom_pkg::DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data valid in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/spom_walker.sv =====
// ----------------------------------------------------------------------------
// spom_walker
// Spiral address generator: keeps row/column position and the four ring
// boundaries, and moves the store address with one shared adder.
// ----------------------------------------------------------------------------
module spom_walker #(
  parameter int DIM_W   = 4,
  parameter int IDX_W   = 3,
  parameter int ADDR_W  = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spom_pkg::spom_walk_ctl_t ctl,
  input  logic [DIM_W-1:0]         nr,
  input  logic [DIM_W-1:0]         nc,
  output logic [ADDR_W-1:0]        addr
);

  // Walk directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Address step selects
  localparam logic [1:0] STEP_INC = 2'd0;
  localparam logic [1:0] STEP_DEC = 2'd1;
  localparam logic [1:0] STEP_DN  = 2'd2;
  localparam logic [1:0] STEP_UP  = 2'd3;

  logic [IDX_W-1:0]  r_r, r_nxt, c_r, c_nxt;
  logic [IDX_W-1:0]  top_r, top_nxt, bot_r, bot_nxt;
  logic [IDX_W-1:0]  lft_r, lft_nxt, rgt_r, rgt_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        step_sel;
  logic [ADDR_W-1:0] delta;
  logic [ADDR_W-1:0] row_step;
  logic [IDX_W:0]    top_p1;

  assign row_step = ADDR_W'(nc);
  assign top_p1   = {1'b0, top_r} + (IDX_W+1)'(1);

  // Shared address adder
  always_comb begin
    unique case (step_sel)
      STEP_INC: delta = ADDR_W'(1);
      STEP_DEC: delta = {ADDR_W{1'b1}};
      STEP_DN:  delta = row_step;
      STEP_UP:  delta = ADDR_W'(0) - row_step;
      default:  delta = ADDR_W'(0);
    endcase
  end

  // Next position along the spiral
  always_comb begin
    r_nxt    = r_r;
    c_nxt    = c_r;
    top_nxt  = top_r;
    bot_nxt  = bot_r;
    lft_nxt  = lft_r;
    rgt_nxt  = rgt_r;
    dir_nxt  = dir_r;
    step_sel = STEP_INC;
    unique case (dir_r)
      DIR_RIGHT: begin
        if (c_r < rgt_r) begin
          c_nxt    = c_r + IDX_W'(1);
          step_sel = STEP_INC;
        end else begin
          r_nxt    = r_r + IDX_W'(1);
          dir_nxt  = DIR_DOWN;
          step_sel = STEP_DN;
        end
      end
      DIR_DOWN: begin
        if (r_r < bot_r) begin
          r_nxt    = r_r + IDX_W'(1);
          step_sel = STEP_DN;
        end else begin
          c_nxt    = c_r - IDX_W'(1);
          dir_nxt  = DIR_LEFT;
          step_sel = STEP_DEC;
        end
      end
      DIR_LEFT: begin
        if (c_r > lft_r) begin
          c_nxt    = c_r - IDX_W'(1);
          step_sel = STEP_DEC;
        end else begin
          r_nxt    = r_r - IDX_W'(1);
          dir_nxt  = DIR_UP;
          step_sel = STEP_UP;
        end
      end
      DIR_UP: begin
        if ({1'b0, r_r} > top_p1) begin
          r_nxt    = r_r - IDX_W'(1);
          step_sel = STEP_UP;
        end else begin
          // ring done: step right into the next ring and shrink bounds
          c_nxt    = c_r + IDX_W'(1);
          dir_nxt  = DIR_RIGHT;
          step_sel = STEP_INC;
          top_nxt  = top_r + IDX_W'(1);
          bot_nxt  = bot_r - IDX_W'(1);
          lft_nxt  = lft_r + IDX_W'(1);
          rgt_nxt  = rgt_r - IDX_W'(1);
        end
      end
      default: begin
        dir_nxt = DIR_RIGHT;
      end
    endcase
    addr_nxt = addr_r + delta;
  end

  // Position and boundary registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_RIGHT;
    end else if (ctl.start) begin
      dir_r <= DIR_RIGHT;
    end else if (ctl.step) begin
      dir_r <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      r_r    <= '0;
      c_r    <= '0;
      top_r  <= '0;
      lft_r  <= '0;
      bot_r  <= IDX_W'(nr - DIM_W'(1));
      rgt_r  <= IDX_W'(nc - DIM_W'(1));
      addr_r <= '0;
    end else if (ctl.step) begin
      r_r    <= r_nxt;
      c_r    <= c_nxt;
      top_r  <= top_nxt;
      bot_r  <= bot_nxt;
      lft_r  <= lft_nxt;
      rgt_r  <= rgt_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign addr = addr_r;

endmodule

// ===== design/spiral_order_matrix_reader_unit.sv =====
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_unit
// Collects a rows x cols matrix in row-major order and replays it in
// clockwise spiral order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one 32-bit signed element per transaction, in
//   row-major order. in_tready stays high throughout loading.
//   The transaction that completes the matrix starts the replay; the
//   input side then holds in_tready low until the last result is taken.
//   Result channel (out_*): rows*cols transactions in spiral order, with
//   out_tlast on the final one. Each result is read from the store in
//   ST_READ and offered in ST_SEND; the next result is not read until
//   the current one is taken. After the completing input transaction
//   the sequencer passes through ST_READ before out_tvalid rises in
//   ST_SEND.
//   A stalled receiver simply holds the current result in the output
//   register; nothing is lost or repeated.
//   Configuration (cfg_*): index 0 = rows, index 1 = cols, each 1..MAX_DIM
//   (0 reads as 1, larger values as MAX_DIM). Write only while idle.
//   Reset: rows = cols = 4, load count cleared; the element store is not
//   cleared, since only elements of the current load are ever read.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spom_pkg::DATA_W-1:0]      in_tdata,    // [31:0] value
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spom_pkg::DATA_W-1:0]      out_tdata,   // [31:0] value_out
  output logic                             out_tlast,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [spom_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [spom_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // Sequencer states
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [spom_pkg::CFG_DATA_W-1:0] rows_r, cols_r;
  logic [1:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0]                emit_cnt_r, emit_cnt_nxt;
  logic                            last_r, last_nxt;
  logic [DIM_W-1:0]                nr, nc;
  logic [CNT_W-1:0]                total;
  logic [CNT_W-1:0]                cnt_inc;
  logic                            in_acc, out_acc;
  logic                            wr_en, rd_en;
  logic [ADDR_W-1:0]               rd_addr;
  spom_pkg::spom_walk_ctl_t        walk_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= spom_pkg::ROWS_RST;
      cols_r <= spom_pkg::COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spom_pkg::REG_ROWS: rows_r <= cfg_wdata;
        spom_pkg::REG_COLS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    if (rows_r == '0)                nr = DIM_W'(1);
    else if (32'(rows_r) > MAX_DIM)  nr = DIM_W'(MAX_DIM);
    else                             nr = DIM_W'(rows_r);
    if (cols_r == '0)                nc = DIM_W'(1);
    else if (32'(cols_r) > MAX_DIM)  nc = DIM_W'(MAX_DIM);
    else                             nc = DIM_W'(cols_r);
  end

  assign total   = CNT_W'(nr) * CNT_W'(nc);
  assign cnt_inc = load_cnt_r + CNT_W'(1);

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_SEND);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  // Store write only inside the store
  assign wr_en = in_acc && (32'(load_cnt_r) < DEPTH);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    emit_cnt_nxt  = emit_cnt_r;
    last_nxt      = last_r;
    walk_ctl      = '0;
    rd_en         = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_inc >= total) begin
            load_cnt_nxt   = '0;
            emit_cnt_nxt   = '0;
            walk_ctl.start = 1'b1;
            state_nxt      = ST_READ;
          end else begin
            load_cnt_nxt = cnt_inc;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        last_nxt  = (emit_cnt_r == total - CNT_W'(1));
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_acc) begin
          if (last_r) begin
            state_nxt = ST_LOAD;
          end else begin
            emit_cnt_nxt  = emit_cnt_r + CNT_W'(1);
            walk_ctl.step = 1'b1;
            state_nxt     = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      emit_cnt_r <= '0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      last_r     <= last_nxt;
    end
  end

  // Spiral address walker
  spom_walker #(
    .DIM_W   (DIM_W),
    .IDX_W   (IDX_W),
    .ADDR_W  (ADDR_W)
  ) u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (walk_ctl),
    .nr    (nr),
    .nc    (nc),
    .addr  (rd_addr)
  );

  // Element store; read data doubles as the output register
  spom_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_cnt_r[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_tdata)
  );

  assign out_tlast = last_r;

endmodule
